[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, sampled on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/lcht_pkg.sv]
// ----------------------------------------------------------------------------
// lcht_pkg
// shared types, constants and the case fold for the lru cache cost tracker
// ----------------------------------------------------------------------------
package lcht_pkg;

  localparam int MAX_WAYS_DEF = 32;
  localparam int KEY_W        = 64;
  localparam int CFG_W        = 6;
  localparam int COST_W       = 32;
  localparam int HIT_COST     = 1;
  localparam int MISS_COST    = 5;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [COST_W-1:0] cost_t;

  // per-cell control from the top level
  typedef struct packed {
    logic cmp_en;    // capture a compare result
    logic cmp_valid; // cell lies below the used count
    logic load;      // take the neighbor's key
  } cell_ctrl_t;

  // fold A-Z to a-z in every byte
  function automatic key_t fold_case(input key_t k);
    key_t       r;
    logic [7:0] b;
    r = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage

[rtl/core/lcht_req_if.sv]
// ----------------------------------------------------------------------------
// lcht_req_if
// request channel: one key per transaction
// ----------------------------------------------------------------------------
interface lcht_req_if;
  import lcht_pkg::*;

  logic valid;
  logic ready;
  key_t key_bytes;

  modport source (output valid, output key_bytes, input ready);
  modport sink (input valid, input key_bytes, output ready);
endinterface

[rtl/core/lcht_rsp_if.sv]
// ----------------------------------------------------------------------------
// lcht_rsp_if
// response channel: hit flag and running cost per transaction
// ----------------------------------------------------------------------------
interface lcht_rsp_if;
  import lcht_pkg::*;

  logic  valid;
  logic  ready;
  logic  was_hit;
  cost_t total_cost;

  modport source (output valid, output was_hit, output total_cost, input ready);
  modport sink (input valid, input was_hit, input total_cost, output ready);
endinterface

[rtl/core/lcht_cell.sv]
// ----------------------------------------------------------------------------
// lcht_cell
// one cache way: holds a key, compares it, shifts in its neighbor's key
// ----------------------------------------------------------------------------
module lcht_cell (
  input  logic               clk,
  input  lcht_pkg::cell_ctrl_t ctrl,
  input  lcht_pkg::key_t     cmp_key,
  input  lcht_pkg::key_t     shift_key,
  output lcht_pkg::key_t     key,
  output logic               match
);
  import lcht_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= shift_key;
    end
    if (ctrl.cmp_en) begin
      match <= ctrl.cmp_valid && (key == cmp_key);
    end
  end

endmodule

[rtl/core/lru_cache_hit_cost_tracker.sv]
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_tracker
// fully associative lru cache built as a chain of key cells, with running cost
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------
//  req      in   valid/ready    key_bytes (64b, case folded inside)
//  rsp      out  valid/ready    was_hit (1b), total_cost (32b)
//  cfg      in   cfg_we         cfg_wdata = ways_in_use (6b)
//
//  per transaction: the accept step folds the key and every cell compares
//  against it, then the update step shifts the cell chain and updates the cost
//  the next request is taken as soon as the update step is done, even while the
//  response register still waits on rsp.ready
//  the update step holds only while the previous response has not been taken
//  rst clears the control state, fill count, cost and ways_in_use; the cell
//  keys are not cleared (never read above the fill count)
//
`include "assert_macros.svh"

module lru_cache_hit_cost_tracker #(
  parameter int MAX_WAYS = lcht_pkg::MAX_WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  lcht_req_if.sink            req,
  lcht_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  lcht_pkg::cfg_t      cfg_wdata
);
  import lcht_pkg::*;

  // way index and way count widths
  localparam int IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  // control state
  logic             busy;        // compare done, chain update pending
  logic             out_valid;
  logic             out_hit;
  cfg_t             ways_in_use;
  logic [CNT_W-1:0] fill_count;
  cost_t            total_cost;

  // captured per transaction
  key_t             fkey;
  logic [CNT_W-1:0] size_q;
  logic [CNT_W-1:0] used_q;

  // cell chain
  key_t                cell_key [MAX_WAYS];
  logic [MAX_WAYS-1:0] match_vec;
  cell_ctrl_t          cell_ctrl [MAX_WAYS];

  logic             accept;
  logic             done;
  key_t             fold_key;
  logic [CNT_W-1:0] size_now;
  logic [CNT_W-1:0] used_now;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] used_m1;
  logic [COST_W:0]  cost_sum;

  assign req.ready      = !busy;
  assign accept         = req.valid && !busy;
  // the update step may finish only if the response register is free
  assign done           = busy && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.was_hit    = out_hit;
  assign rsp.total_cost = total_cost;

  assign fold_key = fold_case(req.key_bytes);

  // clamp configured size to the number of ways, then limit by fill
  always_comb begin
    if (int'(ways_in_use) > MAX_WAYS) begin
      size_now = CNT_W'(MAX_WAYS);
    end else begin
      size_now = CNT_W'(ways_in_use);
    end
    used_now = (fill_count < size_now) ? fill_count : size_now;
  end

  // keys below the used count are distinct, so the match vector has at most one bit set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (match_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // shift point: the hit way, else the first free way, else the lru way
  always_comb begin
    hit     = |match_vec;
    used_m1 = used_q - CNT_W'(1);
    if (hit) begin
      pos = hit_idx;
    end else if (used_q < size_q) begin
      pos = used_q[IDX_W-1:0];
    end else begin
      pos = used_m1[IDX_W-1:0];
    end
  end

  // saturating cost add
  assign cost_sum = {1'b0, total_cost}
                  + (hit ? (COST_W+1)'(HIT_COST) : (COST_W+1)'(MISS_COST));

  // cells: cell 0 takes the new key, cell i takes cell i-1, up to the shift point
  for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
    key_t shift_key;

    if (i == 0) begin : g_head
      assign shift_key = fkey;
    end else begin : g_body
      assign shift_key = cell_key[i-1];
    end

    assign cell_ctrl[i].cmp_en    = accept;
    assign cell_ctrl[i].cmp_valid = CNT_W'(i) < used_now;
    // size zero leaves the store untouched
    assign cell_ctrl[i].load      = done && (size_q != '0) && (IDX_W'(i) <= pos);

    lcht_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .cmp_key   (fold_key),
      .shift_key (shift_key),
      .key       (cell_key[i]),
      .match     (match_vec[i])
    );
  end

  // per-transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      fkey   <= fold_key;
      size_q <= size_now;
      used_q <= used_now;
    end
    if (done) begin
      out_hit <= hit;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      ways_in_use <= '0;
      fill_count  <= '0;
      total_cost  <= '0;
    end else begin
      if (cfg_we) begin
        ways_in_use <= cfg_wdata;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
        total_cost <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        if (size_q != '0) begin
          fill_count <= (!hit && used_q < size_q) ? used_q + CNT_W'(1) : used_q;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_SAME(a_fill_range, 1'b1, fill_count <= CNT_W'(MAX_WAYS))
  `ASSERT_SAME(a_match_unique, busy, $onehot0(match_vec))
  `ASSERT_NEXT(a_accept_busy, req.valid && req.ready, busy)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives keys into the lru cache cost tracker, predicts hit flag and running
// cost for each request, and checks every response in order
// ----------------------------------------------------------------------------
module tb_top;
  import lcht_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_PCT     = 28;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int N_PHASES      = 14;
  localparam int PHASE_ITEMS   = 132;
  localparam int CALM_PHASE    = 4;
  localparam int MODEL_WAYS    = MAX_WAYS_DEF;

  // one response as the cache should report it
  typedef struct packed {
    logic  was_hit;
    cost_t total_cost;
  } lookup_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: keeps its own copy of the cache and the access counters,
  // queues the response each accepted key should produce
  // --------------------------------------------------------------------------
  class lru_cost_scoreboard;
    key_t           cached_keys[MODEL_WAYS]; // entry 0 is most recent
    int unsigned    fill;
    logic [31:0]    hit_count;
    logic [31:0]    miss_count;
    int unsigned    ways;
    lookup_result_t expected_responses[$];
    int             errors;

    function new();
      fill       = 0;
      hit_count  = '0;
      miss_count = '0;
      ways       = 0;
      errors     = 0;
    endfunction

    function void set_ways(cfg_t v);
      ways = v;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    // move entries 0..n-1 one place down, new key goes to the front
    function void promote(int unsigned n, key_t k);
      for (int i = n; i > 0; i--) begin
        cached_keys[i] = cached_keys[i-1];
      end
      cached_keys[0] = k;
    endfunction

    function void note_lookup(key_t raw);
      key_t              k;
      logic [7:0]        b;
      int unsigned       size;
      int unsigned       used;
      int unsigned       pos;
      logic              hit;
      longint unsigned   sum;
      lookup_result_t    r;
      // lower case is upper case with bit 5 set
      k = raw;
      for (int i = 0; i < KEY_W / 8; i++) begin
        b = raw[8*i +: 8];
        if (b >= 8'h41 && b <= 8'h5A) begin
          k[8*i + 5] = 1'b1;
        end
      end
      size = (ways > MODEL_WAYS) ? MODEL_WAYS : ways;
      used = (fill < size) ? fill : size;
      hit  = 1'b0;
      pos  = 0;
      if (size != 0) begin
        // only the most recent entries inside the current size are searched
        for (int i = 0; i < used; i++) begin
          if (!hit && cached_keys[i] == k) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) begin
          promote(pos, k);
          fill = used;
        end else if (used < size) begin
          promote(used, k);
          fill = used + 1;
        end else begin
          // replace the least recent way in range
          promote(used - 1, k);
          fill = used;
        end
      end
      if (hit) begin
        if (hit_count != '1) hit_count++;
      end else begin
        if (miss_count != '1) miss_count++;
      end
      sum = longint'(hit_count) * HIT_COST + longint'(miss_count) * MISS_COST;
      r.was_hit    = hit;
      r.total_cost = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      expected_responses.push_back(r);
    endfunction

    function void check_response(logic was_hit, cost_t total_cost);
      lookup_result_t want;
      if (expected_responses.size() == 0) begin
        $display("%0t: response with nothing outstanding, was_hit %0b total_cost %0d",
                 $time, was_hit, total_cost);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      if (was_hit !== want.was_hit) begin
        $display("%0t: was_hit mismatch, expected %0b actual %0b",
                 $time, want.was_hit, was_hit);
        errors++;
      end
      if (total_cost !== want.total_cost) begin
        $display("%0t: total_cost mismatch, expected %0d actual %0d",
                 $time, want.total_cost, total_cost);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, channels and the block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic cfg_we;
  cfg_t cfg_wdata;
  bit   calm;   // when set neither side pauses

  lcht_req_if req_ch ();
  lcht_rsp_if rsp_ch ();

  lru_cache_hit_cost_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_cost_scoreboard sb = new();
  key_t               key_pool[$];

  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // random pause decision, shared by sender and receiver
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < STALL_PCT);
  endfunction

  // --------------------------------------------------------------------------
  // key generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h41 + 8'($urandom_range(0, 25));
      4, 5, 6:    return 8'h61 + 8'($urandom_range(0, 25));
      7: begin
        // bytes right at the edges of the letter ranges, or 00 and FF
        case ($urandom_range(0, 9))
          0: return 8'h40;
          1: return 8'h41;
          2: return 8'h5A;
          3: return 8'h5B;
          4: return 8'h60;
          5: return 8'h61;
          6: return 8'h7A;
          7: return 8'h7B;
          8: return 8'h00;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // short ascii-ish word, zero padded above its length
  function automatic key_t make_word();
    key_t        w;
    int unsigned len;
    w   = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      w[8*i +: 8] = pick_byte();
    end
    return w;
  endfunction

  // flip the case of some letters so hits must go through the fold
  function automatic key_t recase(key_t k);
    key_t       r;
    logic [7:0] b;
    r = k;
    for (int i = 0; i < KEY_W / 8; i++) begin
      b = k[8*i +: 8];
      if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
          $urandom_range(0, 1) == 1) begin
        r[8*i + 5] = ~b[5];
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  task automatic send_key(input key_t k);
    bit paused;
    paused = 1'b0;
    while (take_break()) begin
      if (!paused) begin
        req_ch.valid <= 1'b0;
        paused = 1'b1;
      end
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.key_bytes <= k;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    // transaction taken at this edge
    sb.note_lookup(k);
  endtask

  // stop requesting and wait for every outstanding response
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_ways(input cfg_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_ways(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // bring the pool to a target size, old keys stay to exercise shrink and grow
  task automatic resize_pool(input int unsigned target);
    while (key_pool.size() > target) begin
      key_pool.delete($urandom_range(0, key_pool.size() - 1));
    end
    while (key_pool.size() < target) begin
      key_pool.push_back(make_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // response sink: check on each taken transaction, random backpressure
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.was_hit, rsp_ch.total_cost);
      end
      rsp_ch.ready <= !take_break();
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too many cycles with no transaction on either channel
  // --------------------------------------------------------------------------
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ways;
    int unsigned target;
    int unsigned sel;
    key_t        k;

    calm             = 1'b0;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.key_bytes <= '0;
    rsp_ch.ready     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // size zero: every access misses, even a repeat
    write_ways(6'd0);
    send_key(64'h0000_0000_0041_4243);
    send_key(64'h0000_0000_0061_6263);

    // four ways: field extremes, fold boundaries, fill, hit, eviction
    write_ways(6'd4);
    send_key(64'h0000_0000_0000_0000);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h4041_5A5B_6061_7A7B);
    send_key(64'h4061_7A5B_6061_7A7B);    // folded form of the previous key
    send_key(64'h0000_0000_0041_4243);
    send_key(64'h0000_0000_0061_6243);    // mixed case, hits
    send_key(64'h0000_0048_454C_4C4F);    // cache full, replaces least recent
    send_key(64'h0000_0000_0000_0000);    // evicted earlier, misses again
    send_key(64'h0000_0068_656C_6C6F);

    // register above the way count acts as the full cache
    write_ways(6'd63);
    send_key(64'h0000_0000_0061_6263);
    send_key(64'h0000_0000_5A5A_5A5A);
    send_key(64'h0000_0000_7A7A_7A7A);

    // shrink below the fill: only the most recent two are searched
    write_ways(6'd2);
    send_key(64'h0000_0000_7A7A_7A7A);
    send_key(64'h0000_0068_656C_6C6F);
    send_key(64'h0000_0000_0000_0000);

    // grow back to the full size
    write_ways(6'd32);
    send_key(64'h0000_0000_0000_0000);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h0000_0000_0041_4243);

    // random phases, each with its own size and a key pool near that size
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0:       ways = 32;
        1:       ways = 1;
        2:       ways = 0;
        3:       ways = 63;
        4:       ways = 3;
        5:       ways = 33;
        default: ways = $urandom_range(0, 63);
      endcase
      write_ways(cfg_t'(ways));
      calm = (phase == CALM_PHASE);
      if (ways == 0) begin
        target = 8;
      end else begin
        if (ways > MODEL_WAYS) ways = MODEL_WAYS;
        target = $urandom_range(ways / 2 + 1, ways + ways / 2 + 2);
      end
      resize_pool(target);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          k = recase(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end else if (sel < 90) begin
          k = make_word();
        end else begin
          k = {$urandom, $urandom};
        end
        send_key(k);
      end
    end
    calm = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
